[rtl/ptc_pkg.sv]
// types, constants and helpers shared by the paged text console
package ptc_pkg;

	// console geometry
	localparam int PAGES = 12;
	localparam int ROWS  = 8;
	localparam int COLS  = 21;

	localparam int PG_W   = $clog2(PAGES);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLS);
	localparam int ADDR_W = PG_W + ROW_W + COL_W;
	localparam int DEPTH  = PAGES << (ROW_W + COL_W);

	// character codes
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// opcodes
	localparam logic [2:0] OP_WRITE  = 3'd0;
	localparam logic [2:0] OP_CURSOR = 3'd1;
	localparam logic [2:0] OP_CLEAR  = 3'd2;
	localparam logic [2:0] OP_SHOW   = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SCROLL_MASK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_MASK = 1'd1;

	typedef struct packed {
		logic [2:0] opcode;
		logic [3:0] page;
		logic [7:0] char_code;
		logic [7:0] col_req;
		logic [7:0] row_req;
	} item_t;

	typedef struct packed {
		logic       shown_write;
		logic [2:0] shown_row;
		logic [4:0] shown_col;
		logic [7:0] data_char;
		logic       refresh_display;
		logic       clear_display;
		logic [2:0] cursor_row;
		logic [4:0] cursor_col;
		logic       cursor_mark;
	} result_t;

	// request to the sweep engine
	typedef struct packed {
		logic             go;
		logic             copy;
		logic [PG_W-1:0]  page;
		logic [ROW_W-1:0] row;
	} sweep_cmd_t;

	// memory traffic and status from the sweep engine
	typedef struct packed {
		logic              active;
		logic              busy;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              wr_fill;
	} sweep_bus_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [PG_W-1:0] pg,
		input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
		return {pg, r, c};
	endfunction

endpackage

[rtl/ptc_ram.sv]
// generic simple dual port ram with registered read
module ptc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/ptc_sweep.sv]
// row copy and fill sequencer for the cell memory
module ptc_sweep (
	input  logic                clk,
	input  logic                arst_n,
	input  ptc_pkg::sweep_cmd_t cmd,
	output ptc_pkg::sweep_bus_t bus
);

	import ptc_pkg::*;

	logic             act_q;
	logic             all_q;
	logic             copy_q;
	logic [PG_W-1:0]  page_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	logic              wr_v_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              fill_s1;

	logic col_last;
	logic row_last;
	logic page_last;

	assign col_last  = (col_q == COL_W'(COLS - 1));
	assign row_last  = (row_q == ROW_W'(ROWS - 1));
	assign page_last = (page_q == PG_W'(PAGES - 1));

	// after reset the engine fills every page with spaces
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b1;
			all_q  <= 1'b1;
			copy_q <= 1'b0;
			page_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (!act_q) begin
			if (cmd.go) begin
				act_q  <= 1'b1;
				all_q  <= 1'b0;
				copy_q <= cmd.copy;
				page_q <= cmd.page;
				row_q  <= cmd.row;
				col_q  <= '0;
			end
		end else if (!col_last) begin
			col_q <= col_q + 1'b1;
		end else begin
			col_q <= '0;
			if (!row_last) begin
				row_q <= row_q + 1'b1;
			end else if (copy_q) begin
				copy_q <= 1'b0;
			end else if (all_q && !page_last) begin
				page_q <= page_q + 1'b1;
				row_q  <= '0;
			end else begin
				act_q <= 1'b0;
				all_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_s1 <= 1'b0;
		end else begin
			wr_v_s1 <= act_q;
		end
	end

	always_ff @(posedge clk) begin
		fill_s1 <= !copy_q;
		if (copy_q) begin
			wr_addr_s1 <= cell_addr(page_q, row_q - 1'b1, col_q);
		end else begin
			wr_addr_s1 <= cell_addr(page_q, row_q, col_q);
		end
	end

	assign bus.active  = act_q;
	assign bus.busy    = act_q || wr_v_s1;
	assign bus.rd_addr = cell_addr(page_q, row_q, col_q);
	assign bus.wr_en   = wr_v_s1;
	assign bus.wr_addr = wr_addr_s1;
	assign bus.wr_fill = fill_s1;

	a_cmd_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> !act_q)
		else $error("sweep started while running");

	a_copy_row_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(act_q && copy_q) |-> (row_q != '0))
		else $error("row copy from row zero");

	a_fill_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(act_q) |-> wr_v_s1)
		else $error("last sweep write lost");

endmodule

[rtl/paged_text_console_scroll.sv]
// paged text console: pages of character cells with per-page cursor and scroll
//
// channel   direction  handshake                     word
// command   in         start & !busy                 item (opcode, page, char, col, row)
// result    out        done, one cycle, no stall     result (cell write, redraw, cursor)
// config    in         cfg_valid & cfg_ready         cfg_index, cfg_data
//
// every accepted word yields one result word in the next cycle
// write, set cursor, show and read finish without a sweep unless a write scrolls; a read
// returns the cell from the memory's registered port in the result cycle
// a scroll holds busy while it moves rows up and fills the bottom row with spaces, up to
// the last write (ROWS-1 rows of COLS cells move with no header, one row less with a
// header); a page clear holds busy while it sets every cell of the page to space
// after reset busy stays high while every cell is set to space; cfg_ready stays high
// throughout
module paged_text_console_scroll (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  ptc_pkg::item_t                    item,
	output logic                              done,
	output ptc_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ptc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ptc_pkg::PAGES-1:0]         cfg_data
);

	import ptc_pkg::*;

	// configuration masks, one bit per page
	logic [PAGES-1:0] scroll_mask_q;
	logic [PAGES-1:0] header_mask_q;

	// per-page cursors and the visible page
	logic [COL_W-1:0] cur_col_q [PAGES];
	logic [ROW_W-1:0] cur_row_q [PAGES];
	logic [3:0]       vis_q;

	// result register
	logic    done_q;
	logic    rd_q;
	result_t res_q;

	// cell memory ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	sweep_cmd_t sw_cmd;
	sweep_bus_t sw_bus;

	// decode of the accepted word
	logic             accept;
	logic             item_ok;
	logic [PG_W-1:0]  pg;
	logic             vis;
	logic             scr;
	logic [COL_W-1:0] cc;
	logic [ROW_W-1:0] rr;
	logic [COL_W-1:0] x;
	logic [ROW_W:0]   y;
	logic             store;
	logic             cur_we;
	logic             vis_we;
	logic             rd_op;
	result_t          res_d;

	assign accept    = start && !busy;
	assign busy      = sw_bus.busy;
	assign cfg_ready = 1'b1;
	assign item_ok   = (item.page < 4'(PAGES)) && (item.opcode <= OP_READ);
	assign pg        = item.page[PG_W-1:0];
	assign vis       = (item.page == vis_q);
	assign scr       = scroll_mask_q[pg];
	assign cc        = (item.col_req >= 8'(COLS)) ? COL_W'(COLS - 1) : item.col_req[COL_W-1:0];
	assign rr        = (item.row_req >= 8'(ROWS)) ? ROW_W'(ROWS - 1) : item.row_req[ROW_W-1:0];

	always_comb begin
		res_d  = '0;
		x      = cur_col_q[pg];
		y      = {1'b0, cur_row_q[pg]};
		store  = 1'b0;
		cur_we = 1'b0;
		vis_we = 1'b0;
		rd_op  = 1'b0;
		sw_cmd = '0;
		sw_cmd.page = pg;
		if (accept && item_ok) begin
			case (item.opcode)
				OP_WRITE: begin
					cur_we = 1'b1;
					if (item.char_code == CH_LF) begin
						x = '0;
						y = y + 1'b1;
					end else if (item.char_code == CH_CR) begin
						x = '0;
					end else begin
						// store at the cursor and advance, wrapping at the row end
						store             = 1'b1;
						res_d.data_char   = item.char_code;
						res_d.shown_write = vis;
						res_d.shown_row   = vis ? 3'(y) : 3'd0;
						res_d.shown_col   = vis ? 5'(x) : 5'd0;
						if (x == COL_W'(COLS - 1)) begin
							x = '0;
							y = y + 1'b1;
						end else begin
							x = x + 1'b1;
						end
					end
					if (y != (ROW_W + 1)'(ROWS)) begin
						res_d.cursor_mark = scr && vis;
					end else if (!scr) begin
						// plain wrap to the top row
						y = '0;
					end else begin
						// scroll: rows move up, bottom row is blanked
						y = (ROW_W + 1)'(ROWS - 1);
						sw_cmd.go = 1'b1;
						if (header_mask_q[pg] && (ROWS > 2)) begin
							sw_cmd.copy = 1'b1;
							sw_cmd.row  = ROW_W'(2);
						end else if (header_mask_q[pg]) begin
							sw_cmd.copy = 1'b0;
							sw_cmd.row  = ROW_W'(ROWS - 1);
						end else begin
							sw_cmd.copy = 1'b1;
							sw_cmd.row  = ROW_W'(1);
						end
						res_d.refresh_display = vis;
						res_d.cursor_mark     = vis;
					end
				end
				OP_CURSOR: begin
					cur_we = 1'b1;
					x = cc;
					y = {1'b0, rr};
				end
				OP_CLEAR: begin
					cur_we = 1'b1;
					x = '0;
					y = '0;
					sw_cmd.go   = 1'b1;
					sw_cmd.copy = 1'b0;
					sw_cmd.row  = '0;
					res_d.clear_display = vis;
				end
				OP_SHOW: begin
					if (!vis) begin
						vis_we = 1'b1;
						res_d.refresh_display = 1'b1;
						res_d.cursor_mark     = scr;
					end
				end
				OP_READ: begin
					rd_op = 1'b1;
				end
				default: begin
					rd_op = 1'b0;
				end
			endcase
			res_d.cursor_row = 3'(y);
			res_d.cursor_col = 5'(x);
		end
	end

	// memory port selection: sweep traffic wins, busy keeps new words out meanwhile
	always_comb begin
		if (sw_bus.wr_en) begin
			ram_we    = 1'b1;
			ram_waddr = sw_bus.wr_addr;
			ram_wdata = sw_bus.wr_fill ? CH_SPACE : ram_rdata;
		end else begin
			ram_we    = store;
			ram_waddr = cell_addr(pg, cur_row_q[pg], cur_col_q[pg]);
			ram_wdata = item.char_code;
		end
		ram_raddr = sw_bus.active ? sw_bus.rd_addr : cell_addr(pg, rr, cc);
	end

	ptc_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ptc_sweep u_sweep (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (sw_cmd),
		.bus   (sw_bus)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_mask_q <= '0;
			header_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCROLL_MASK: scroll_mask_q <= cfg_data;
				REG_HEADER_MASK: header_mask_q <= cfg_data;
				default: begin
					scroll_mask_q <= scroll_mask_q;
				end
			endcase
		end
	end

	// cursors and visible page
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAGES; i++) begin
				cur_col_q[i] <= '0;
				cur_row_q[i] <= '0;
			end
			vis_q <= '0;
		end else begin
			if (cur_we) begin
				cur_col_q[pg] <= x;
				cur_row_q[pg] <= y[ROW_W-1:0];
			end
			if (vis_we) begin
				vis_q <= item.page;
			end
		end
	end

	// result register, one word per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			rd_q   <= 1'b0;
		end else begin
			done_q <= accept;
			rd_q   <= rd_op;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	// a read takes the cell straight from the memory's output register
	always_comb begin
		result = res_q;
		if (rd_q) begin
			result.data_char = ram_rdata;
		end
	end

	assign done = done_q;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted word produced no result");

	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		sw_bus.wr_en |-> !store)
		else $error("cell write collides with sweep write");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.cursor_col < 5'(COLS)) &&
			({1'b0, result.cursor_row} < (ROW_W + 1)'(ROWS))))
		else $error("cursor out of range");

	a_refresh_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.refresh_display && result.clear_display))
		else $error("redraw and clear in one result");

endmodule

[tb/console_checker.sv]
`timescale 1ns / 100ps
// result checker for the paged text console: predicts each result word and compares it
module console_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  ptc_pkg::item_t                item,
	input  logic                          done,
	input  ptc_pkg::result_t              result,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [ptc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ptc_pkg::PAGES-1:0]     cfg_data,
	output int                            mismatches,
	output int                            outstanding,
	output int                            results_seen,
	output int                            scrolls_seen
);

	import ptc_pkg::*;

	// shadow copy of the console
	logic [7:0]       cells [PAGES][ROWS][COLS];
	logic [COL_W-1:0] cur_col [PAGES];
	logic [ROW_W-1:0] cur_row [PAGES];
	logic [3:0]       shown_page;
	logic [PAGES-1:0] scroll_bits;
	logic [PAGES-1:0] header_bits;

	result_t predicted_results [$];

	function automatic string word_text(input result_t r);
		return {$sformatf("write=%0d at %0d,%0d char=%02h",
				r.shown_write, r.shown_row, r.shown_col, r.data_char),
			$sformatf(" refresh=%0d clear=%0d cursor=%0d,%0d mark=%0d",
				r.refresh_display, r.clear_display, r.cursor_row, r.cursor_col,
				r.cursor_mark)};
	endfunction

	// applies one command word to the shadow console and returns its result word
	function automatic result_t console_step(input item_t w);
		result_t r;
		logic    vis;
		logic    scr;
		int      pg;
		int      x;
		int      y;
		int      cc;
		int      rr;
		int      k;
		int      j;
		r = '0;
		if (w.page >= PAGES || w.opcode > OP_READ)
			return r;
		pg  = w.page;
		vis = (w.page == shown_page);
		scr = scroll_bits[pg];
		x   = cur_col[pg];
		y   = cur_row[pg];
		cc  = (w.col_req >= COLS) ? COLS - 1 : w.col_req;
		rr  = (w.row_req >= ROWS) ? ROWS - 1 : w.row_req;
		case (w.opcode)
			OP_WRITE: begin
				if (w.char_code == CH_LF) begin
					x = 0;
					y++;
				end else if (w.char_code == CH_CR) begin
					x = 0;
				end else begin
					cells[pg][y][x] = w.char_code;
					r.data_char = w.char_code;
					if (vis) begin
						r.shown_write = 1'b1;
						r.shown_row   = ROW_W'(y);
						r.shown_col   = COL_W'(x);
					end
					x++;
					if (x >= COLS) begin
						x = 0;
						y++;
					end
				end
				if (y < ROWS) begin
					r.cursor_mark = scr && vis;
				end else if (!scr) begin
					y = 0;
				end else begin
					// move rows up, row 0 stays when the header bit is set
					for (k = header_bits[pg] ? 2 : 1; k < ROWS; k++)
						for (j = 0; j < COLS; j++)
							cells[pg][k-1][j] = cells[pg][k][j];
					for (j = 0; j < COLS; j++)
						cells[pg][ROWS-1][j] = CH_SPACE;
					y = ROWS - 1;
					scrolls_seen++;
					if (vis) begin
						r.refresh_display = 1'b1;
						r.cursor_mark     = 1'b1;
					end
				end
				cur_col[pg] = COL_W'(x);
				cur_row[pg] = ROW_W'(y);
			end
			OP_CURSOR: begin
				cur_col[pg] = COL_W'(cc);
				cur_row[pg] = ROW_W'(rr);
			end
			OP_CLEAR: begin
				for (k = 0; k < ROWS; k++)
					for (j = 0; j < COLS; j++)
						cells[pg][k][j] = CH_SPACE;
				cur_col[pg] = '0;
				cur_row[pg] = '0;
				r.clear_display = vis;
			end
			OP_SHOW: begin
				if (!vis) begin
					shown_page        = w.page;
					r.refresh_display = 1'b1;
					r.cursor_mark     = scr;
				end
			end
			default: begin
				r.data_char = cells[pg][rr][cc];
			end
		endcase
		r.cursor_row = cur_row[pg];
		r.cursor_col = cur_col[pg];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		string   bad;
		int      p;
		int      k;
		int      j;
		if (!arst_n) begin
			for (p = 0; p < PAGES; p++) begin
				cur_col[p] = '0;
				cur_row[p] = '0;
				for (k = 0; k < ROWS; k++)
					for (j = 0; j < COLS; j++)
						cells[p][k][j] = CH_SPACE;
			end
			shown_page  = '0;
			scroll_bits = '0;
			header_bits = '0;
			predicted_results.delete();
			mismatches   = 0;
			outstanding  = 0;
			results_seen = 0;
			scrolls_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SCROLL_MASK)
					scroll_bits = cfg_data;
				else if (cfg_index == REG_HEADER_MASK)
					header_bits = cfg_data;
			end
			if (start && !busy)
				predicted_results.push_back(console_step(item));
			if (done) begin
				if (predicted_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result word with none expected: %s", $realtime,
							word_text(result));
				end else begin
					want = predicted_results.pop_front();
					results_seen++;
					bad = "";
					if (result.shown_write !== want.shown_write)         bad = {bad, " shown_write"};
					if (result.shown_row !== want.shown_row)             bad = {bad, " shown_row"};
					if (result.shown_col !== want.shown_col)             bad = {bad, " shown_col"};
					if (result.data_char !== want.data_char)             bad = {bad, " data_char"};
					if (result.refresh_display !== want.refresh_display) bad = {bad, " refresh_display"};
					if (result.clear_display !== want.clear_display)     bad = {bad, " clear_display"};
					if (result.cursor_row !== want.cursor_row)           bad = {bad, " cursor_row"};
					if (result.cursor_col !== want.cursor_col)           bad = {bad, " cursor_col"};
					if (result.cursor_mark !== want.cursor_mark)         bad = {bad, " cursor_mark"};
					if (bad != "") begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: result word %0d differs in%s", $realtime,
								results_seen, bad);
							$display("  expected %s", word_text(want));
							$display("  actual   %s", word_text(result));
						end
					end
				end
			end
			outstanding = predicted_results.size();
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// top of the console regression: clock, reset, command and config stimulus, verdict
module testbench;
	import ptc_pkg::*;

	// generous bound: every command a full-page sweep plus a long gap, several times over
	localparam int LIMIT       = 1_500_000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 258;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	item_t                item;
	logic                 done;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PAGES-1:0]     cfg_data;

	int mismatches;
	int outstanding;
	int results_seen;
	int scrolls_seen;
	int issued;

	paged_text_console_scroll u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// watches every channel, predicts and compares
	console_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.done         (done),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.scrolls_seen (scrolls_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop if the run hangs somewhere
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles <= LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("paged_text_console_scroll regression: fail");
		$finish;
	end

	// builds one command word
	function automatic item_t cmd(input logic [2:0] op, input logic [3:0] pg,
		input logic [7:0] ch, input logic [7:0] col, input logic [7:0] row);
		item_t w;
		w.opcode    = op;
		w.page      = pg;
		w.char_code = ch;
		w.col_req   = col;
		w.row_req   = row;
		return w;
	endfunction

	// mostly back to back or short gaps, now and then a long one
	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return 0;
		else if (pick < 85)
			return $urandom_range(1, 3);
		else if (pick < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// random command aimed mostly at one page so its cursor runs to the bottom and scrolls
	function automatic item_t make_command(input logic [3:0] focus);
		item_t w;
		int    pick;
		w.char_code = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126));
		w.col_req   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, COLS + 2));
		w.row_req   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, ROWS + 2));
		pick = $urandom_range(0, 99);
		if (pick < 80)
			w.page = focus;
		else if (pick < 95)
			w.page = 4'($urandom_range(0, PAGES - 1));
		else
			w.page = 4'($urandom_range(PAGES, (1 << $bits(w.page)) - 1));
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			w.opcode = OP_WRITE;
		end else if (pick < 63) begin
			w.opcode    = OP_WRITE;
			w.char_code = CH_LF;
		end else if (pick < 66) begin
			w.opcode    = OP_WRITE;
			w.char_code = CH_CR;
		end else if (pick < 74) begin
			w.opcode = OP_CURSOR;
		end else if (pick < 77) begin
			w.opcode = OP_CLEAR;
		end else if (pick < 84) begin
			w.opcode = OP_SHOW;
		end else if (pick < 97) begin
			w.opcode = OP_READ;
		end else begin
			// undefined opcodes, must come back all zero
			w.opcode = 3'($urandom_range(int'(OP_READ) + 1, (1 << $bits(w.opcode)) - 1));
		end
		return w;
	endfunction

	// hold start with the word until the block takes it, return on the next falling edge
	task automatic issue(input item_t w);
		start = 1'b1;
		item  = w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		issued++;
		@(negedge clk);
	endtask

	// idle the command side for some cycles, junk on the bus meanwhile
	task automatic skip(input int n);
		if (n > 0) begin
			start = 1'b0;
			item  = item_t'($urandom);
			repeat (n) @(negedge clk);
		end
	endtask

	// wait until every expected word is back and any scroll or clear sweep has finished
	task automatic settle();
		start = 1'b0;
		while (outstanding != 0 || busy)
			@(negedge clk);
	endtask

	// register write, only with the block idle
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [PAGES-1:0] data);
		settle();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin : stimulus
		logic [3:0]       focus;
		logic [PAGES-1:0] scroll_set;
		logic [PAGES-1:0] header_set;
		int               p;
		int               n;
		issued    = 0;
		arst_n    = 1'b0;
		start     = 1'b0;
		item      = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: page 0 scrolls with a header, page 11 scrolls without, page 5 wraps
		cfg_write(REG_SCROLL_MASK, 12'h801);
		cfg_write(REG_HEADER_MASK, 12'h001);
		issue(cmd(OP_WRITE, 4'd0, "A", 8'd0, 8'd0));
		issue(cmd(OP_WRITE, 4'd0, 8'hff, 8'd0, 8'd0));
		issue(cmd(OP_WRITE, 4'd0, 8'h00, 8'd0, 8'd0));
		issue(cmd(OP_WRITE, 4'd0, CH_CR, 8'd0, 8'd0));
		issue(cmd(OP_WRITE, 4'd0, CH_LF, 8'd0, 8'd0));
		// clamp on both axes, then run off the last cell so the header page scrolls
		issue(cmd(OP_CURSOR, 4'd0, 8'd0, 8'hff, 8'hff));
		issue(cmd(OP_WRITE, 4'd0, "Z", 8'd0, 8'd0));
		issue(cmd(OP_READ, 4'd0, 8'd0, 8'd0, 8'd0));
		// hidden page scrolls on a line feed from the bottom row
		issue(cmd(OP_CURSOR, 4'd11, 8'd0, 8'd0, 8'd7));
		issue(cmd(OP_WRITE, 4'd11, CH_LF, 8'd0, 8'd0));
		// page without scroll wraps back to row 0
		issue(cmd(OP_CURSOR, 4'd5, 8'd0, 8'd20, 8'd7));
		issue(cmd(OP_WRITE, 4'd5, "q", 8'd0, 8'd0));
		// show a scrolling page, show it again, write to it, then a plain page
		issue(cmd(OP_SHOW, 4'd11, 8'd0, 8'd0, 8'd0));
		issue(cmd(OP_SHOW, 4'd11, 8'd0, 8'd0, 8'd0));
		issue(cmd(OP_WRITE, 4'd11, "x", 8'd0, 8'd0));
		issue(cmd(OP_SHOW, 4'd5, 8'd0, 8'd0, 8'd0));
		// clear of the visible page and of a hidden one
		issue(cmd(OP_CLEAR, 4'd5, 8'd0, 8'd0, 8'd0));
		issue(cmd(OP_CLEAR, 4'd3, 8'd0, 8'd0, 8'd0));
		issue(cmd(OP_SHOW, 4'd0, 8'd0, 8'd0, 8'd0));
		issue(cmd(OP_READ, 4'd11, 8'd0, 8'hff, 8'hff));
		// pages past the last one and undefined opcodes do nothing
		issue(cmd(OP_WRITE, 4'd12, "a", 8'd0, 8'd0));
		issue(cmd(OP_READ, 4'd15, 8'd0, 8'd0, 8'd0));
		issue(cmd(3'(int'(OP_READ) + 1), 4'd0, "b", 8'd1, 8'd1));
		issue(cmd(3'((1 << $bits(item.opcode)) - 1), 4'd0, "c", 8'd2, 8'd2));

		// random phases, each with its own mask setting, fixed extremes in phases 0, 1, 2 and 4
		focus = '0;
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					scroll_set = '0;
					header_set = '0;
				end
				1: begin
					scroll_set = '1;
					header_set = '1;
				end
				2: begin
					scroll_set = '1;
					header_set = '0;
				end
				4: begin
					scroll_set = '0;
					header_set = '1;
				end
				default: begin
					scroll_set = PAGES'($urandom);
					header_set = PAGES'($urandom);
				end
			endcase
			cfg_write(REG_SCROLL_MASK, scroll_set);
			cfg_write(REG_HEADER_MASK, header_set);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 60 == 0)
					focus = 4'($urandom_range(0, PAGES - 1));
				// one drain in the middle of a phase
				if (p == 3 && n == PHASE_ITEMS / 2)
					settle();
				issue(make_command(focus));
				// phase 2 runs flat out, the others leave stretches without gaps
				if (p != 2 && (n / 40) % 3 != 1)
					skip(gap_len());
			end
		end

		settle();
		repeat (8) @(negedge clk);
		$display("ran %0d commands under %0d mask settings, %0d result words checked",
			issued, PHASES + 1, results_seen);
		$display("%0d page scrolls predicted along the way, %0d mismatches",
			scrolls_seen, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("paged_text_console_scroll regression: pass");
		else
			$display("paged_text_console_scroll regression: fail");
		$finish;
	end

endmodule

[files.f]
rtl/ptc_pkg.sv
rtl/ptc_ram.sv
rtl/ptc_sweep.sv
rtl/paged_text_console_scroll.sv
tb/console_checker.sv
tb/testbench.sv
